FILE: rtl/core/avt_pkg.sv
package avt_pkg;

  localparam int DATA_W      = 32;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int IDX_W       = 4;
  localparam int N_ELEM      = 16;
  localparam int N_COMP      = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = 1;
  localparam int CNT_W       = 2;

  // Command codes on the input channel.
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_POINT = 2'd1;
  localparam logic [1:0] CMD_DIR   = 2'd2;
  localparam logic [1:0] CMD_ROW   = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_POINT,
    OP_DIR,
    OP_ROW
  } op_e;

  // One queued operation. For a load, a0 carries the coefficient and idx
  // its position; for a transform, a0..a2 carry the vector.
  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] a0;
    logic [DATA_W-1:0] a1;
    logic [DATA_W-1:0] a2;
  } q_entry_t;

endpackage

FILE: rtl/core/avt_stream_if.sv
interface avt_in_if
  import avt_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [IDX_W-1:0]         elem_index;
  logic signed [DATA_W-1:0] elem_value;
  logic signed [DATA_W-1:0] vec_x;
  logic signed [DATA_W-1:0] vec_y;
  logic signed [DATA_W-1:0] vec_z;

  modport source (
    output valid, command, elem_index, elem_value, vec_x, vec_y, vec_z,
    input  ready
  );
  modport sink (
    input  valid, command, elem_index, elem_value, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

interface avt_out_if
  import avt_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_x;
  logic signed [DATA_W-1:0] out_y;
  logic signed [DATA_W-1:0] out_z;
  logic                     overflow;

  modport source (
    output valid, out_x, out_y, out_z, overflow,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, overflow,
    output ready
  );
endinterface

FILE: rtl/core/avt_front.sv
module avt_front
  import avt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  avt_in_if.sink   vtx_i,
  output q_entry_t head_o,
  output logic     head_valid_o,
  input  logic     pop_i
);

  q_entry_t         entry_d;
  q_entry_t         entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic             push;

  // Ready depends on the registered fill level only, so the back end's
  // stall never reaches the input channel combinationally.
  assign vtx_i.ready  = (count_q != CNT_W'(QUEUE_DEPTH));
  assign push         = vtx_i.valid && vtx_i.ready;
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];
  assign count_d      = count_q + CNT_W'(push) - CNT_W'(pop_i);

  always_comb begin
    entry_d.idx = vtx_i.elem_index;
    entry_d.a0  = vtx_i.vec_x;
    entry_d.a1  = vtx_i.vec_y;
    entry_d.a2  = vtx_i.vec_z;
    unique case (vtx_i.command)
      CMD_LOAD: begin
        entry_d.op = OP_LOAD;
        entry_d.a0 = vtx_i.elem_value;
      end
      CMD_POINT: begin
        entry_d.op = OP_POINT;
      end
      CMD_DIR: begin
        entry_d.op = OP_DIR;
      end
      CMD_ROW: begin
        entry_d.op = OP_ROW;
      end
      default: begin
        entry_d.op = OP_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= entry_d;
    end
  end

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue popped while empty");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill level beyond depth");

  a_count_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill level lost a transfer");

endmodule

FILE: rtl/core/avt_back.sv
module avt_back
  import avt_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_entry_t head_i,
  input  logic     head_valid_i,
  output logic     pop_o,
  avt_out_if.source vtx_o
);

  localparam int SH_W  = PROD_W - FRAC_BITS;
  localparam int SUM_W = (SH_W + 2 > COORD_WIDTH + 1) ? SH_W + 2 : COORD_WIDTH + 1;
  localparam int UP_W  = SUM_W - COORD_WIDTH + 1;
  localparam logic [DATA_W-1:0] UNITY   = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [SUM_W-1:0]  SAT_MAX = {{UP_W{1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [SUM_W-1:0]  SAT_MIN = ~SAT_MAX;

  logic signed [DATA_W-1:0] matrix_q [N_ELEM];
  logic signed [DATA_W-1:0] vec      [N_COMP];
  logic signed [DATA_W-1:0] coef     [N_COMP][N_COMP];
  logic signed [DATA_W-1:0] addend_d [N_COMP];
  logic signed [DATA_W-1:0] addend_q [N_COMP];
  logic signed [PROD_W-1:0] prod_q   [N_COMP][N_COMP];
  logic signed [SH_W-1:0]   shifted  [N_COMP][N_COMP];
  logic signed [SUM_W-1:0]  sum      [N_COMP];
  logic [UP_W-1:0]          upper    [N_COMP];
  logic [SUM_W-1:0]         clamped  [N_COMP];
  logic [DATA_W-1:0]        out_d    [N_COMP];
  logic [DATA_W-1:0]        out_q    [N_COMP];
  logic [N_COMP-1:0]        sat;
  logic                     ovf_q;
  logic                     p_valid_q;
  logic                     o_valid_q;
  logic                     out_ready;
  logic                     p_free;
  logic                     is_load;
  logic                     issue;

  assign out_ready = !o_valid_q || vtx_o.ready;
  assign p_free    = !p_valid_q || out_ready;
  assign is_load   = (head_i.op == OP_LOAD);
  // A load never enters the pipeline, so it may leave the queue during a stall.
  assign pop_o     = head_valid_i && (is_load || p_free);
  assign issue     = pop_o && !is_load;

  assign vec[0] = $signed(head_i.a0);
  assign vec[1] = $signed(head_i.a1);
  assign vec[2] = $signed(head_i.a2);

  // Coefficient selection: columns for the point and direction forms,
  // rows for the row-vector form.
  always_comb begin
    for (int r = 0; r < N_COMP; r++) begin
      if (head_i.op == OP_ROW) begin
        for (int k = 0; k < N_COMP; k++) begin
          coef[r][k] = matrix_q[4*r + k];
        end
        addend_d[r] = matrix_q[4*r + 3];
      end else begin
        for (int k = 0; k < N_COMP; k++) begin
          coef[r][k] = matrix_q[4*k + r];
        end
        addend_d[r] = (head_i.op == OP_POINT) ? matrix_q[12 + r] : '0;
      end
    end
  end

  // Arithmetic shift floors each product; the exact sum is then clamped.
  always_comb begin
    for (int r = 0; r < N_COMP; r++) begin
      for (int k = 0; k < N_COMP; k++) begin
        shifted[r][k] = SH_W'(prod_q[r][k] >>> FRAC_BITS);
      end
      sum[r] = SUM_W'(shifted[r][0]) + SUM_W'(shifted[r][1])
             + SUM_W'(shifted[r][2]) + SUM_W'(addend_q[r]);
      upper[r] = sum[r][SUM_W-1:COORD_WIDTH-1];
      sat[r]   = !((&upper[r]) || !(|upper[r]));
      if (sat[r]) begin
        clamped[r] = sum[r][SUM_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        clamped[r] = sum[r];
      end
      out_d[r] = clamped[r][DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N_ELEM; i++) begin
        matrix_q[i] <= (i == 0 || i == 5 || i == 10 || i == 15) ? UNITY : '0;
      end
    end else if (pop_o && is_load) begin
      matrix_q[head_i.idx] <= $signed(head_i.a0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (p_free) begin
        p_valid_q <= issue;
      end
      if (out_ready) begin
        o_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      for (int r = 0; r < N_COMP; r++) begin
        for (int k = 0; k < N_COMP; k++) begin
          prod_q[r][k] <= coef[r][k] * vec[k];
        end
        addend_q[r] <= addend_d[r];
      end
    end
    if (p_valid_q && out_ready) begin
      for (int r = 0; r < N_COMP; r++) begin
        out_q[r] <= out_d[r];
      end
      ovf_q <= |sat;
    end
  end

  assign vtx_o.valid    = o_valid_q;
  assign vtx_o.out_x    = $signed(out_q[0]);
  assign vtx_o.out_y    = $signed(out_q[1]);
  assign vtx_o.out_z    = $signed(out_q[2]);
  assign vtx_o.overflow = ovf_q;

  a_pop_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i)
    else $error("operation taken from an empty queue");

  a_issue_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> p_valid_q)
    else $error("issued transform lost before the product stage");

  a_prod_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && !out_ready) |=> (p_valid_q && $stable(addend_q[0])))
    else $error("product stage changed while stalled");

endmodule

FILE: rtl/core/affine_vertex_transform_top.sv
// Affine 4x4 vertex transform with a Q-format coefficient matrix.
//
// Items arrive on vtx_i (valid/ready) and results leave on vtx_o. A load
// command writes one matrix coefficient and gives no result; the point,
// direction and row-vector commands each give one result on vtx_o.
// Accepted items pass through a two-entry queue into the back end, where
// nine multipliers form all products into the product registers and a second stage sums,
// floors and saturates them into the output register.
// A transform accepted on vtx_i passes from the queue through the product
// registers to the output register. Throughput is one item per cycle while
// vtx_o does not stall, set by the single pass through the multipliers;
// loads never wait on them. At reset the matrix returns to identity and the
// queue and pipeline empty. When the receiver stalls, the output and product
// stages hold, the queue fills, and vtx_i.ready drops once both entries are
// occupied; a load at the queue head still updates the matrix, in order.
module affine_vertex_transform_top
  import avt_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  avt_in_if.sink    vtx_i,
  avt_out_if.source vtx_o
);

  q_entry_t head;
  logic     head_valid;
  logic     pop;

  avt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vtx_i        (vtx_i),
    .head_o       (head),
    .head_valid_o (head_valid),
    .pop_i        (pop)
  );

  avt_back #(
    .FRAC_BITS   (FRAC_BITS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .vtx_o        (vtx_o)
  );

endmodule
